### sv/rrq_pkg.sv
// rrq_pkg: shared types and constants for the round-robin queue with expedite
// used by rrq_cell and round_robin_queue_with_expedite; no dependencies
package rrq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_WIDTH = 16;
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_SERVE    = 2'd1,
    OP_EXPEDITE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_INIT,
    SEL_NEXT,
    SEL_FRONT,
    SEL_PREV,
    SEL_ID
  } sel_e;

  typedef struct packed {
    sel_e                sel;
    logic [ID_WIDTH-1:0] init_val;
  } cell_ctrl_t;

endpackage

### sv/rrq_cell.sv
// rrq_cell: one list slot; compares its id and loads from a neighbor or a broadcast
// depends on rrq_pkg
module rrq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrq_pkg::cell_ctrl_t          ctrl_i,
  input  logic [rrq_pkg::ID_WIDTH-1:0] prev_i,
  input  logic [rrq_pkg::ID_WIDTH-1:0] next_i,
  input  logic [rrq_pkg::ID_WIDTH-1:0] front_i,
  input  logic [rrq_pkg::ID_WIDTH-1:0] id_i,
  output logic [rrq_pkg::ID_WIDTH-1:0] val_o,
  output logic                         match_o
);

  logic [rrq_pkg::ID_WIDTH-1:0] val_q, val_d;

  always_comb begin
    unique case (ctrl_i.sel)
      rrq_pkg::SEL_INIT:  val_d = ctrl_i.init_val;
      rrq_pkg::SEL_NEXT:  val_d = next_i;
      rrq_pkg::SEL_FRONT: val_d = front_i;
      rrq_pkg::SEL_PREV:  val_d = prev_i;
      rrq_pkg::SEL_ID:    val_d = id_i;
      default:            val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o   = val_q;
  assign match_o = (val_q == id_i);

endmodule

### sv/round_robin_queue_with_expedite.sv
// round_robin_queue_with_expedite: top level, a row of rrq_cell slots plus length
// and output registers; depends on rrq_pkg and rrq_cell
//
// Keeps an ordered list of up to 64 distinct 16-bit ids in a row of slots, one
// id per slot. init loads ids 1..min(population, 64), serve returns the front id
// and rotates it to the back, expedite moves or inserts an id at the front
// (dropping the last one when full). All slots compare and shift in the same
// cycle, so a word is accepted in every cycle while the result register is free
// or being taken. Only serve words produce a result word.
module round_robin_queue_with_expedite (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] served_id_o,
  output logic        was_empty_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAP  = rrq_pkg::CAPACITY;
  localparam int IDW  = rrq_pkg::ID_WIDTH;
  localparam int LENW = rrq_pkg::LEN_W;

  logic [15:0]     pop_q;
  logic [LENW-1:0] len_q, len_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     served_q, served_d;
  logic            empty_q, empty_d;

  logic [IDW-1:0]       vals [CAP];
  logic [CAP-1:0]       match_v;
  logic [CAP-1:0]       hit_below;
  rrq_pkg::cell_ctrl_t  ctrl [CAP];
  logic [IDW-1:0]       id_m;
  logic                 accept;
  logic                 any_hit;
  logic [LENW-1:0]      init_n;

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? {16'd0, pop_q} : 32'd0;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign id_m       = id_i[IDW-1:0];
  assign any_hit    = |match_v;
  assign init_n     = (pop_q < 16'(CAP)) ? LENW'(pop_q) : LENW'(CAP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      pop_q <= pwdata[15:0];
    end
  end

  // prefix hit: some slot in front of k holds the id
  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      hit_below[k] = |(match_v & ~({CAP{1'b1}} << k));
    end
  end

  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      ctrl[k].sel      = rrq_pkg::SEL_HOLD;
      ctrl[k].init_val = (LENW'(k) < init_n) ? IDW'(k + 1) : '0;
      if (accept) begin
        unique case (op_i)
          rrq_pkg::OP_INIT: begin
            ctrl[k].sel = rrq_pkg::SEL_INIT;
          end
          rrq_pkg::OP_SERVE: begin
            if (len_q != '0) begin
              if ((LENW'(k) + LENW'(1)) == len_q) begin
                ctrl[k].sel = rrq_pkg::SEL_FRONT;
              end else if ((LENW'(k) + LENW'(1)) < len_q) begin
                ctrl[k].sel = rrq_pkg::SEL_NEXT;
              end
            end
          end
          rrq_pkg::OP_EXPEDITE: begin
            if (id_m != '0) begin
              if (k == 0) begin
                ctrl[k].sel = rrq_pkg::SEL_ID;
              end else if (!hit_below[k]) begin
                ctrl[k].sel = rrq_pkg::SEL_PREV;
              end
            end
          end
          default: ctrl[k].sel = rrq_pkg::SEL_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [IDW-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = vals[g-1];
    end
    if (g == CAP - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = vals[g+1];
    end
    rrq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[g]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .front_i (vals[0]),
      .id_i    (id_m),
      .val_o   (vals[g]),
      .match_o (match_v[g])
    );
  end

  always_comb begin
    len_d       = len_q;
    out_valid_d = out_valid_q & out_stall_i;
    served_d    = served_q;
    empty_d     = empty_q;
    if (accept) begin
      unique case (op_i)
        rrq_pkg::OP_INIT: begin
          len_d = init_n;
        end
        rrq_pkg::OP_SERVE: begin
          out_valid_d = 1'b1;
          served_d    = 16'(vals[0]);
          empty_d     = (len_q == '0);
        end
        rrq_pkg::OP_EXPEDITE: begin
          if ((id_m != '0) && !any_hit && (len_q < LENW'(CAP))) begin
            len_d = len_q + LENW'(1);
          end
        end
        default: len_d = len_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
      served_q    <= '0;
      empty_q     <= 1'b0;
    end else begin
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      served_q    <= served_d;
      empty_q     <= empty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign served_id_o = served_q;
  assign was_empty_o = empty_q;

endmodule

### tb/round_robin_queue_with_expedite_test.sv
// round_robin_queue_with_expedite_test: self-checking testbench that predicts every
// serve word of the queue and compares it with the word the block returns
// depends on rrq_pkg and round_robin_queue_with_expedite
module round_robin_queue_with_expedite_test;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [2:0] REG_POPULATION = 3'd0;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int          PEND_DEPTH    = 16;
  localparam int          PEND_AW       = 4;

  typedef struct packed {
    logic [15:0] served_id;
    logic        was_empty;
  } serve_word_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i        = rrq_pkg::OP_INIT;
  logic [15:0] id_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] served_id_o;
  logic        was_empty_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted queue contents
  logic [rrq_pkg::ID_WIDTH-1:0] queue_ids [rrq_pkg::CAPACITY];
  int unsigned                  queue_len;
  logic [15:0]                  population;

  // serve words still to come out of the block
  serve_word_t      pending_words [PEND_DEPTH];
  logic [PEND_AW:0] pend_wr = '0;
  logic [PEND_AW:0] pend_rd = '0;

  bit          gaps_on = 1'b0;
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;

  round_robin_queue_with_expedite i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void expect_serve(input serve_word_t w);
    if ((pend_wr[PEND_AW] != pend_rd[PEND_AW]) &&
        (pend_wr[PEND_AW-1:0] == pend_rd[PEND_AW-1:0])) begin
      $error("too many serve words pending");
      fails++;
    end else begin
      pending_words[pend_wr[PEND_AW-1:0]] = w;
      pend_wr = pend_wr + 1'b1;
    end
  endfunction

  function automatic void advance_queue(input logic [1:0] op, input logic [15:0] id);
    int unsigned n;
    int unsigned pos;
    logic [rrq_pkg::ID_WIDTH-1:0] front;
    case (op)
      rrq_pkg::OP_INIT: begin
        n = (population < rrq_pkg::CAPACITY) ? population : rrq_pkg::CAPACITY;
        for (int k = 0; k < rrq_pkg::CAPACITY; k++) begin
          queue_ids[k] = (k < n) ? rrq_pkg::ID_WIDTH'(k + 1) : '0;
        end
        queue_len = n;
      end
      rrq_pkg::OP_SERVE: begin
        if (queue_len == 0) begin
          expect_serve('{served_id: 16'd0, was_empty: 1'b1});
        end else begin
          front = queue_ids[0];
          for (int k = 1; k < queue_len; k++) begin
            queue_ids[k-1] = queue_ids[k];
          end
          queue_ids[queue_len-1] = front;
          expect_serve('{served_id: front, was_empty: 1'b0});
        end
      end
      rrq_pkg::OP_EXPEDITE: begin
        if (id != '0) begin
          pos = queue_len;
          for (int k = 0; k < queue_len; k++) begin
            if (pos == queue_len && queue_ids[k] == id) pos = k;
          end
          // absent id grows the list, or drops the last entry when full
          if (pos == queue_len) begin
            if (queue_len < rrq_pkg::CAPACITY) queue_len++;
            pos = queue_len - 1;
          end
          for (int k = pos; k > 0; k--) begin
            queue_ids[k] = queue_ids[k-1];
          end
          queue_ids[0] = id;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] id);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    id_i       <= id;
    do @(posedge clk_i); while (in_stall_o);
    advance_queue(op, id);
  endtask

  task automatic settle_queue();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_population(input logic [15:0] value);
    settle_queue();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_POPULATION;
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    population = value;
  endtask

  function automatic logic [1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return rrq_pkg::OP_INIT;
    if (r < 50) return rrq_pkg::OP_SERVE;
    if (r < 97) return rrq_pkg::OP_EXPEDITE;
    return OP_UNUSED;
  endfunction

  task automatic random_phase(input int unsigned items, input int unsigned id_pool,
                              input bit wide_ids);
    logic [15:0] id;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 49) == 0) id = '0;
      else if (wide_ids && $urandom_range(0, 1) == 0) id = 16'($urandom_range(0, 65535));
      else id = 16'($urandom_range(1, id_pool));
      send_word(pick_op(), id);
    end
  endtask

  task automatic test_directed();
    set_population(16'd0);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    send_word(rrq_pkg::OP_INIT, 16'hFFFF);
    send_word(rrq_pkg::OP_SERVE, 16'hFFFF);
    send_word(rrq_pkg::OP_EXPEDITE, 16'h0000);
    send_word(OP_UNUSED, 16'h5A5A);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    send_word(rrq_pkg::OP_EXPEDITE, 16'hFFFF);
    send_word(rrq_pkg::OP_EXPEDITE, 16'h0001);
    send_word(rrq_pkg::OP_EXPEDITE, 16'hFFFF);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    set_population(16'd5);
    send_word(rrq_pkg::OP_INIT, 16'h0000);
    send_word(rrq_pkg::OP_EXPEDITE, 16'd3);
    send_word(rrq_pkg::OP_EXPEDITE, 16'd5);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    // population above capacity, then insert into a full list
    set_population(16'hFFFF);
    send_word(rrq_pkg::OP_INIT, 16'h0000);
    send_word(rrq_pkg::OP_EXPEDITE, 16'h8000);
    send_word(rrq_pkg::OP_EXPEDITE, 16'd64);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
    set_population(16'(rrq_pkg::CAPACITY));
    send_word(rrq_pkg::OP_INIT, 16'h0000);
    send_word(rrq_pkg::OP_SERVE, 16'h0000);
  endtask

  task automatic test_random_short_lists();
    for (int p = 0; p < 4; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      set_population(16'($urandom_range(0, 12)));
      random_phase(200, 12, 1'b0);
    end
  endtask

  task automatic test_random_full_lists();
    logic [15:0] sizes [3];
    sizes[0] = 16'(rrq_pkg::CAPACITY);
    sizes[1] = 16'hFFFF;
    sizes[2] = 16'($urandom_range(0, 65535));
    for (int p = 0; p < 3; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      set_population(sizes[p]);
      random_phase(200, 90, 1'b1);
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    set_population(16'($urandom_range(rrq_pkg::CAPACITY - 8, rrq_pkg::CAPACITY + 8)));
    random_phase(200, 80, 1'b1);
  endtask

  initial begin
    for (int k = 0; k < rrq_pkg::CAPACITY; k++) queue_ids[k] = '0;
    queue_len  = 0;
    population = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_short_lists();
    test_random_full_lists();
    test_steady_stream();
    settle_queue();
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side stalls in bursts
  initial begin
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) out_stall_i <= 1'b1;
      else out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_served
    serve_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pend_wr == pend_rd) begin
        $error("result word with no serve pending: served_id %0d was_empty %0d",
               served_id_o, was_empty_o);
        fails++;
      end else begin
        want    = pending_words[pend_rd[PEND_AW-1:0]];
        pend_rd = pend_rd + 1'b1;
        if (served_id_o !== want.served_id) begin
          $error("served_id: expected %0d, actual %0d", want.served_id, served_id_o);
          fails++;
        end
        if (was_empty_o !== want.was_empty) begin
          $error("was_empty: expected %0d, actual %0d", want.was_empty, was_empty_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
